// ===== rtl/carf_pkg.sv =====
// shared constants, register codes and control structs for the cave automaton row filter
// no dependencies
package carf_pkg;

    localparam int ROW_BITS      = 64;
    localparam int MAX_WIDTH_DEF = 64;
    localparam int WIDTH_BITS    = 7;
    localparam int HEIGHT_BITS   = 16;
    localparam int NEAR_BITS     = 4;
    localparam int FAR_BITS      = 6;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 16;
    localparam int WIN_ROWS      = 5;

    localparam logic [WIDTH_BITS-1:0]         GRID_WIDTH_RST  = 7'd40;
    localparam logic [HEIGHT_BITS-1:0]        GRID_HEIGHT_RST = 16'd40;
    localparam logic [NEAR_BITS-1:0]          NEAR_CUTOFF_RST = 4'd5;
    localparam logic signed [FAR_BITS-1:0]    FAR_CUTOFF_RST  = 6'sd2;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_GRID_WIDTH  = 2'd0,
        REG_GRID_HEIGHT = 2'd1,
        REG_NEAR_CUTOFF = 2'd2,
        REG_FAR_CUTOFF  = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic [NEAR_BITS-1:0]        near_cutoff;
        logic signed [FAR_BITS-1:0]  far_cutoff;
    } t_cut;

    typedef struct packed {
        logic                   interior;
        logic [WIDTH_BITS-1:0]  width;
    } t_merge_ctl;

endpackage

// ===== rtl/carf_lane.sv =====
// one cell lane: counts walls in the 3x3 and the cornerless 5x5 window, applies both cutoffs
// depends on carf_pkg
module carf_lane (
    input  logic [4:0][4:0]    i_nbhd,
    input  carf_pkg::t_cut     i_cut,
    output logic               o_wall
);

    logic [1:0] w_n1, w_n2, w_n3;
    logic [3:0] w_near_cnt;
    logic [1:0] w_f0, w_f4;
    logic [2:0] w_f1, w_f2, w_f3;
    logic [4:0] w_far_cnt;

    // near window: rows 1..3, columns 1..3
    assign w_n1 = 2'(i_nbhd[1][1]) + 2'(i_nbhd[1][2]) + 2'(i_nbhd[1][3]);
    assign w_n2 = 2'(i_nbhd[2][1]) + 2'(i_nbhd[2][2]) + 2'(i_nbhd[2][3]);
    assign w_n3 = 2'(i_nbhd[3][1]) + 2'(i_nbhd[3][2]) + 2'(i_nbhd[3][3]);
    assign w_near_cnt = 4'(w_n1) + 4'(w_n2) + 4'(w_n3);

    // far window: outer rows skip their corners
    assign w_f0 = 2'(i_nbhd[0][1]) + 2'(i_nbhd[0][2]) + 2'(i_nbhd[0][3]);
    assign w_f4 = 2'(i_nbhd[4][1]) + 2'(i_nbhd[4][2]) + 2'(i_nbhd[4][3]);
    assign w_f1 = 3'(i_nbhd[1][0]) + 3'(i_nbhd[1][1]) + 3'(i_nbhd[1][2])
                + 3'(i_nbhd[1][3]) + 3'(i_nbhd[1][4]);
    assign w_f2 = 3'(i_nbhd[2][0]) + 3'(i_nbhd[2][1]) + 3'(i_nbhd[2][2])
                + 3'(i_nbhd[2][3]) + 3'(i_nbhd[2][4]);
    assign w_f3 = 3'(i_nbhd[3][0]) + 3'(i_nbhd[3][1]) + 3'(i_nbhd[3][2])
                + 3'(i_nbhd[3][3]) + 3'(i_nbhd[3][4]);
    assign w_far_cnt = 5'(w_f0) + 5'(w_f4) + 5'(w_f1) + 5'(w_f2) + 5'(w_f3);

    assign o_wall = (w_near_cnt >= i_cut.near_cutoff)
                 || ($signed({1'b0, w_far_cnt}) <= $signed(i_cut.far_cutoff));

endmodule

// ===== rtl/carf_merge.sv =====
// merge stage: takes lane decisions for interior columns of interior rows, the center row elsewhere
// depends on carf_pkg
module carf_merge #(
    parameter int P_MAX_WIDTH = carf_pkg::MAX_WIDTH_DEF
) (
    input  logic [P_MAX_WIDTH-1:0]   i_lane_wall,
    input  logic [P_MAX_WIDTH-1:0]   i_center,
    input  carf_pkg::t_merge_ctl     i_ctl,
    output logic [P_MAX_WIDTH-1:0]   o_cells
);

    assign o_cells[0] = i_center[0];

    for (genvar x = 1; x < P_MAX_WIDTH; x++) begin : g_col
        localparam logic [carf_pkg::WIDTH_BITS-1:0] LIM = carf_pkg::WIDTH_BITS'(x + 2);
        // column x is interior when x <= width - 2
        assign o_cells[x] = (i_ctl.interior && (i_ctl.width >= LIM))
                          ? i_lane_wall[x] : i_center[x];
    end

endmodule

// ===== rtl/cave_automaton_row_filter.sv =====
// cave automaton row filter, top level: row history, job window, lane array, output register
// an accepted row loads the job window, whose result words then go to the output register
// throughput: one row per cycle while the output is not stalled; the frame's last row holds
// the input for three words (two or one in shorter frames), as the flushed rows share the lanes
// reset: synchronous active low; clears row history, row counter, valids, restores registers
// depends on carf_pkg, carf_lane, carf_merge
module cave_automaton_row_filter #(
    parameter int P_MAX_WIDTH = carf_pkg::MAX_WIDTH_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [carf_pkg::CFG_IDX_BITS-1:0]     i_cfg_index,
    input  logic [carf_pkg::CFG_DATA_BITS-1:0]    i_cfg_data,
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  logic [carf_pkg::ROW_BITS-1:0]         i_row_cells,
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output logic [carf_pkg::ROW_BITS-1:0]         o_out_cells,
    output logic [carf_pkg::HEIGHT_BITS-1:0]      o_out_row_index,
    output logic                                  o_last_of_run,
    output logic                                  o_last_of_frame
);

    localparam int WB = carf_pkg::WIDTH_BITS;
    localparam int HB = carf_pkg::HEIGHT_BITS;
    localparam int NR = carf_pkg::WIN_ROWS;

    // configuration
    logic [WB-1:0]                        r_grid_width;
    logic [HB-1:0]                        r_grid_height;
    logic [carf_pkg::NEAR_BITS-1:0]       r_near_cutoff;
    logic signed [carf_pkg::FAR_BITS-1:0] r_far_cutoff;

    // stream state
    logic [P_MAX_WIDTH-1:0] r_hist [4];
    logic [HB-1:0]          r_rows_seen;

    // job window
    logic                   r_job_valid;
    logic [1:0]             r_job_cnt;
    logic [HB-1:0]          r_job_row;
    logic [P_MAX_WIDTH-1:0] r_job_rows [NR];

    // output word
    logic                   r_o_valid;
    logic [P_MAX_WIDTH-1:0] r_o_cells;
    logic [HB-1:0]          r_o_row_index;
    logic                   r_o_lor;
    logic                   r_o_lof;

    logic [WB-1:0]          w_width;
    logic [P_MAX_WIDTH-1:0] w_mask;
    logic [P_MAX_WIDTH-1:0] w_cur;
    logic [HB-1:0]          w_last;
    logic                   w_out_free;
    logic                   w_step;
    logic                   w_job_done;
    logic                   w_accept;
    logic                   w_y_ge2;
    logic                   w_is_last;
    logic [4:0]             w_have;
    logic [P_MAX_WIDTH-1:0] w_win [7];
    logic [1:0]             n_job_cnt;
    logic [1:0]             n_shift;
    logic [HB-1:0]          n_job_row;
    logic [P_MAX_WIDTH-1:0] n_job_rows [NR];
    logic [P_MAX_WIDTH+3:0] w_pad [NR];
    logic [P_MAX_WIDTH-1:0] w_lane_wall;
    logic [P_MAX_WIDTH-1:0] w_result;
    carf_pkg::t_cut         w_cut;
    carf_pkg::t_merge_ctl   w_mctl;

    assign w_width = (r_grid_width > WB'(P_MAX_WIDTH)) ? WB'(P_MAX_WIDTH) : r_grid_width;

    for (genvar x = 0; x < P_MAX_WIDTH; x++) begin : g_mask
        assign w_mask[x] = (w_width > WB'(x));
    end

    assign w_cur  = i_row_cells[P_MAX_WIDTH-1:0] & w_mask;
    assign w_last = r_grid_height - HB'(1);

    // handshake
    assign w_out_free = !r_o_valid || i_out_ready;
    assign w_step     = r_job_valid && w_out_free;
    assign w_job_done = w_step && (r_job_cnt == 2'd1);
    assign o_in_ready = !r_job_valid || w_job_done;
    assign w_accept   = i_in_valid && o_in_ready;

    // rows y-4 .. y+2 around the incoming row, zeroed where outside the frame
    for (genvar k = 0; k < 5; k++) begin : g_have
        assign w_have[k] = (({1'b0, r_rows_seen} + 17'(k)) >= 17'd4)
                        && (({1'b0, r_rows_seen} + 17'(k)) <= ({1'b0, w_last} + 17'd4));
    end

    // history rows are masked to the width in use now
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            w_win[k] = w_have[k] ? (r_hist[3-k] & w_mask) : '0;
        end
        w_win[4] = w_have[4] ? w_cur : '0;
        w_win[5] = '0;
        w_win[6] = '0;
    end

    assign w_y_ge2   = (r_rows_seen >= HB'(2));
    assign w_is_last = (r_rows_seen == w_last);

    always_comb begin
        if (w_y_ge2) begin
            n_job_cnt = w_is_last ? 2'd3 : 2'd1;
            n_shift   = 2'd0;
            n_job_row = r_rows_seen - HB'(2);
        end else begin
            n_job_cnt = !w_is_last ? 2'd0 : (r_rows_seen[0] ? 2'd2 : 2'd1);
            n_shift   = r_rows_seen[0] ? 2'd1 : 2'd2;
            n_job_row = '0;
        end
        for (int j = 0; j < NR; j++) begin
            case (n_shift)
                2'd0:    n_job_rows[j] = w_win[j];
                2'd1:    n_job_rows[j] = w_win[j+1];
                default: n_job_rows[j] = w_win[j+2];
            endcase
        end
    end

    // configuration port
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_width  <= carf_pkg::GRID_WIDTH_RST;
            r_grid_height <= carf_pkg::GRID_HEIGHT_RST;
            r_near_cutoff <= carf_pkg::NEAR_CUTOFF_RST;
            r_far_cutoff  <= carf_pkg::FAR_CUTOFF_RST;
        end else if (i_cfg_we) begin
            case (carf_pkg::t_reg_idx'(i_cfg_index))
                carf_pkg::REG_GRID_WIDTH:  r_grid_width  <= i_cfg_data[WB-1:0];
                carf_pkg::REG_GRID_HEIGHT: r_grid_height <= i_cfg_data[HB-1:0];
                carf_pkg::REG_NEAR_CUTOFF:
                    r_near_cutoff <= i_cfg_data[carf_pkg::NEAR_BITS-1:0];
                carf_pkg::REG_FAR_CUTOFF:
                    r_far_cutoff  <= $signed(i_cfg_data[carf_pkg::FAR_BITS-1:0]);
                default: ;
            endcase
        end
    end

    // row history and row counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 4; i++) begin
                r_hist[i] <= '0;
            end
            r_rows_seen <= '0;
        end else if (w_accept) begin
            r_hist[3]   <= r_hist[2];
            r_hist[2]   <= r_hist[1];
            r_hist[1]   <= r_hist[0];
            r_hist[0]   <= w_cur;
            r_rows_seen <= w_is_last ? '0 : r_rows_seen + HB'(1);
        end
    end

    // job window: loaded on accept, slides one row per emitted word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_job_valid <= 1'b0;
            r_job_cnt   <= '0;
        end else if (w_accept) begin
            r_job_valid <= (n_job_cnt != 2'd0);
            r_job_cnt   <= n_job_cnt;
        end else if (w_step) begin
            r_job_valid <= (r_job_cnt != 2'd1);
            r_job_cnt   <= r_job_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_job_row <= n_job_row;
            for (int j = 0; j < NR; j++) begin
                r_job_rows[j] <= n_job_rows[j];
            end
        end else if (w_step) begin
            r_job_row <= r_job_row + HB'(1);
            for (int j = 0; j < NR - 1; j++) begin
                r_job_rows[j] <= r_job_rows[j+1];
            end
            r_job_rows[NR-1] <= '0;
        end
    end

    // lane array
    assign w_cut.near_cutoff = r_near_cutoff;
    assign w_cut.far_cutoff  = r_far_cutoff;

    for (genvar j = 0; j < NR; j++) begin : g_pad
        assign w_pad[j] = {2'b00, r_job_rows[j], 2'b00};
    end

    for (genvar x = 0; x < P_MAX_WIDTH; x++) begin : g_lane
        logic [4:0][4:0] w_nbhd;
        for (genvar j = 0; j < NR; j++) begin : g_r
            for (genvar c = 0; c < 5; c++) begin : g_c
                assign w_nbhd[j][c] = w_pad[j][x+c];
            end
        end
        carf_lane u_lane (
            .i_nbhd (w_nbhd),
            .i_cut  (w_cut),
            .o_wall (w_lane_wall[x])
        );
    end

    assign w_mctl.interior = (r_job_row >= HB'(1)) && (r_job_row < w_last);
    assign w_mctl.width    = w_width;

    carf_merge #(
        .P_MAX_WIDTH (P_MAX_WIDTH)
    ) u_merge (
        .i_lane_wall (w_lane_wall),
        .i_center    (r_job_rows[2]),
        .i_ctl       (w_mctl),
        .o_cells     (w_result)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (w_step) begin
            r_o_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_o_cells     <= w_result;
            r_o_row_index <= r_job_row;
            r_o_lor       <= (r_job_cnt == 2'd1);
            r_o_lof       <= (r_job_row == w_last);
        end
    end

    assign o_out_valid     = r_o_valid;
    assign o_out_cells     = carf_pkg::ROW_BITS'(r_o_cells);
    assign o_out_row_index = r_o_row_index;
    assign o_last_of_run   = r_o_lor;
    assign o_last_of_frame = r_o_lof;

    // checks
    a_job_cnt_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_job_valid |-> (r_job_cnt != 2'd0))
        else $error("job window valid with no words left");

    a_flush_three: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_is_last && w_y_ge2) |=> (r_job_valid && (r_job_cnt == 2'd3)))
        else $error("frame end did not load a three word flush");

    a_frame_end_closes_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_last_of_frame) |-> o_last_of_run)
        else $error("last row of frame is not the last word of its run");

    a_no_accept_mid_job: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_job_valid && (r_job_cnt != 2'd1)) |-> !o_in_ready)
        else $error("row accepted while job window still has words");

endmodule

// ===== verif/cave_automaton_row_filter_tb.sv =====
`timescale 1ns / 1ps
// self-checking testbench for cave_automaton_row_filter: streams wall/floor rows, predicts each
// next-generation row in place and compares every output word; depends on carf_pkg and the rtl
module cave_automaton_row_filter_tb;

    localparam int STALL_LIMIT = 2000;
    localparam int PAUSE       = 8;
    localparam int RB          = carf_pkg::ROW_BITS;
    localparam int HB          = carf_pkg::HEIGHT_BITS;
    localparam int DB          = carf_pkg::CFG_DATA_BITS;

    typedef struct packed {
        logic [RB-1:0] cells;
        logic [HB-1:0] row_idx;
        logic          run_end;
        logic          frame_end;
    } t_cave_row;

    logic                               i_clk = 1'b0;
    logic                               i_rst_n = 1'b0;
    logic                               i_cfg_we = 1'b0;
    logic [carf_pkg::CFG_IDX_BITS-1:0]  i_cfg_index = '0;
    logic [DB-1:0]                      i_cfg_data = '0;
    logic                               i_in_valid = 1'b0;
    logic                               o_in_ready;
    logic [RB-1:0]                      i_row_cells = '0;
    logic                               o_out_valid;
    logic                               i_out_ready = 1'b0;
    logic [RB-1:0]                      o_out_cells;
    logic [HB-1:0]                      o_out_row_index;
    logic                               o_last_of_run;
    logic                               o_last_of_frame;

    // register shadows and generation state
    logic [carf_pkg::WIDTH_BITS-1:0]      cfg_width = carf_pkg::GRID_WIDTH_RST;
    logic [HB-1:0]                        cfg_height = carf_pkg::GRID_HEIGHT_RST;
    logic [carf_pkg::NEAR_BITS-1:0]       cfg_near = carf_pkg::NEAR_CUTOFF_RST;
    logic signed [carf_pkg::FAR_BITS-1:0] cfg_far = carf_pkg::FAR_CUTOFF_RST;
    logic [RB-1:0]                        prior_rows [0:3] = '{default: '0};
    logic [HB-1:0]                        frame_row = '0;
    logic [RB-1:0]                        win_rows [0:6];
    bit                                   win_have [0:6];

    logic [RB-1:0] rows_to_send [$];
    t_cave_row     expected_rows [$];
    bit            row_taken = 1'b0;
    int            idle_pct = 31;
    int            errors = 0;

    cave_automaton_row_filter dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_row_cells     (i_row_cells),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_out_cells     (o_out_cells),
        .o_out_row_index (o_out_row_index),
        .o_last_of_run   (o_last_of_run),
        .o_last_of_frame (o_last_of_frame)
    );

    always #6 i_clk = ~i_clk;

    function automatic int wall_at(logic [RB-1:0] bits, int x, int w);
        if (x < 0 || x >= w)
            return 0;
        return int'(bits[x]);
    endfunction

    function automatic logic [RB-1:0] next_row_state(int r, int k, int w, int last,
                                                     logic [RB-1:0] mask);
        logic [RB-1:0] src;
        logic [RB-1:0] res;
        int x, dy, dx, near_n, far_n, far_lim;
        far_lim = cfg_far;
        src = win_have[k] ? (win_rows[k] & mask) : '0;
        res = src;
        if (r < 1 || r >= last)
            return src;
        for (x = 1; x <= w - 2; x++) begin
            near_n = 0;
            far_n = 0;
            for (dy = -1; dy <= 1; dy++)
                if (win_have[k + dy])
                    for (dx = -1; dx <= 1; dx++)
                        near_n += wall_at(win_rows[k + dy], x + dx, w);
            for (dy = -2; dy <= 2; dy++) begin
                if (win_have[k + dy]) begin
                    for (dx = -2; dx <= 2; dx++)
                        if (!((dy == 2 || dy == -2) && (dx == 2 || dx == -2)))
                            far_n += wall_at(win_rows[k + dy], x + dx, w);
                end
            end
            res[x] = (near_n >= int'(cfg_near)) || (far_n <= far_lim);
        end
        return res & mask;
    endfunction

    // one accepted row: queue the rows it completes and advance the history
    task automatic step_generation(logic [RB-1:0] row_in);
        int w, y, last, n, r, i, k, idx;
        int due [3];
        logic [RB-1:0] mask;
        logic [RB-1:0] cur;
        t_cave_row res;
        w = (cfg_width > 64) ? 64 : int'(cfg_width);
        mask = (w >= 64) ? '1 : ((64'd1 << w) - 64'd1);
        y = int'(frame_row);
        last = (int'(cfg_height) + 65535) & 65535;
        cur = row_in & mask;
        for (k = 0; k < 4; k++)
            win_rows[k] = prior_rows[3 - k];
        win_rows[4] = cur;
        win_rows[5] = '0;
        win_rows[6] = '0;
        for (k = 0; k < 7; k++) begin
            idx = y - 4 + k;
            win_have[k] = (idx >= 0 && idx <= y && idx <= last);
        end
        n = 0;
        if (y >= 2) begin
            due[n] = y - 2;
            n++;
        end
        if (y == last) begin
            if (y >= 1) begin
                due[n] = y - 1;
                n++;
            end
            due[n] = y;
            n++;
        end
        for (i = 0; i < n; i++) begin
            r = due[i];
            res.cells = next_row_state(r, r - y + 4, w, last, mask);
            res.row_idx = r[HB-1:0];
            res.run_end = (i == n - 1);
            res.frame_end = (r == last);
            expected_rows.push_back(res);
        end
        for (k = 3; k > 0; k--)
            prior_rows[k] = prior_rows[k - 1];
        prior_rows[0] = cur;
        frame_row = (y == last) ? '0 : HB'(y + 1);
    endtask

    // input side: sample at the rising edge, drive at the falling edge
    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && o_in_ready) begin
            step_generation(i_row_cells);
            row_taken = 1'b1;
        end
    end

    always @(negedge i_clk) begin : driver
        logic          nxt_valid;
        logic [RB-1:0] nxt_row;
        nxt_valid = i_in_valid;
        nxt_row = i_row_cells;
        if (row_taken) begin
            nxt_valid = 1'b0;
            row_taken = 1'b0;
        end
        if (!nxt_valid && rows_to_send.size() != 0 && $urandom_range(99) >= idle_pct) begin
            nxt_row = rows_to_send.pop_front();
            nxt_valid = 1'b1;
        end
        i_in_valid <= nxt_valid;
        i_row_cells <= nxt_row;
    end

    always @(negedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= idle_pct);
    end

    always @(posedge i_clk) begin : monitor
        t_cave_row want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_rows.size() == 0) begin
                $display("%0t: unexpected word: row %0d cells %h", $time, o_out_row_index,
                         o_out_cells);
                errors++;
            end else begin
                want = expected_rows.pop_front();
                if (o_out_cells !== want.cells) begin
                    $display("%0t: out_cells expected %h got %h", $time, want.cells,
                             o_out_cells);
                    errors++;
                end
                if (o_out_row_index !== want.row_idx) begin
                    $display("%0t: out_row_index expected %0d got %0d", $time, want.row_idx,
                             o_out_row_index);
                    errors++;
                end
                if (o_last_of_run !== want.run_end) begin
                    $display("%0t: last_of_run expected %b got %b", $time, want.run_end,
                             o_last_of_run);
                    errors++;
                end
                if (o_last_of_frame !== want.frame_end) begin
                    $display("%0t: last_of_frame expected %b got %b", $time, want.frame_end,
                             o_last_of_frame);
                    errors++;
                end
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || i_cfg_we || (i_in_valid && o_in_ready) ||
                (o_out_valid && i_out_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic logic [RB-1:0] random_row();
        logic [RB-1:0] a;
        logic [RB-1:0] b;
        a = {$urandom, $urandom};
        b = {$urandom, $urandom};
        case ($urandom_range(3))
            0: return a & b;
            1: return a | b;
            2: return a;
            default: return a ^ (b & {$urandom, $urandom});
        endcase
    endfunction

    task automatic queue_rows(int n);
        repeat (n) rows_to_send.push_back(random_row());
    endtask

    // unused upper data bits carry noise
    task automatic write_reg(carf_pkg::t_reg_idx idx, int value);
        logic [DB-1:0] data;
        int rw;
        case (idx)
            carf_pkg::REG_GRID_WIDTH:  rw = carf_pkg::WIDTH_BITS;
            carf_pkg::REG_GRID_HEIGHT: rw = carf_pkg::HEIGHT_BITS;
            carf_pkg::REG_NEAR_CUTOFF: rw = carf_pkg::NEAR_BITS;
            default:                   rw = carf_pkg::FAR_BITS;
        endcase
        data = DB'(value);
        if (rw < DB)
            data = (data & ((16'd1 << rw) - 16'd1)) | (DB'($urandom) << rw);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        case (idx)
            carf_pkg::REG_GRID_WIDTH:  cfg_width = data[carf_pkg::WIDTH_BITS-1:0];
            carf_pkg::REG_GRID_HEIGHT: cfg_height = data[HB-1:0];
            carf_pkg::REG_NEAR_CUTOFF: cfg_near = data[carf_pkg::NEAR_BITS-1:0];
            default:                   cfg_far = data[carf_pkg::FAR_BITS-1:0];
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic settle();
        while (rows_to_send.size() != 0 || i_in_valid || expected_rows.size() != 0)
            @(posedge i_clk);
        repeat (PAUSE) @(posedge i_clk);
    endtask

    task automatic set_all(int w, int h, int nc, int fc);
        write_reg(carf_pkg::REG_GRID_WIDTH, w);
        write_reg(carf_pkg::REG_GRID_HEIGHT, h);
        write_reg(carf_pkg::REG_NEAR_CUTOFF, nc);
        write_reg(carf_pkg::REG_FAR_CUTOFF, fc);
    endtask

    initial begin : stimulus
        int sent, n, h, nc, fc;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings, then a height change partway into the frame
        rows_to_send.push_back('1);
        rows_to_send.push_back('0);
        rows_to_send.push_back({16{4'hA}});
        settle();
        write_reg(carf_pkg::REG_GRID_HEIGHT, 5);
        queue_rows(1);
        rows_to_send.push_back({16{4'h5}});
        settle();

        // full width, nothing can become wall
        set_all(64, 3, 10, -1);
        rows_to_send.push_back('1);
        rows_to_send.push_back({1'b1, 62'd0, 1'b1});
        queue_rows(1);
        settle();

        // oversized width, one-row frames
        set_all(127, 1, 9, 21);
        rows_to_send.push_back('1);
        queue_rows(1);
        settle();

        // narrow widths and short frames
        set_all(0, 2, 5, 2);
        rows_to_send.push_back('1);
        rows_to_send.push_back('1);
        settle();
        set_all(1, 1, 5, 2);
        rows_to_send.push_back('1);
        settle();
        set_all(2, 3, 0, 0);
        queue_rows(3);
        settle();

        // smallest real grid with stray bits above the width
        set_all(3, 4, 5, 2);
        rows_to_send.push_back('1);
        rows_to_send.push_back('0);
        rows_to_send.push_back('1);
        queue_rows(1);
        settle();
        set_all(64, 3, 0, -32);
        queue_rows(3);
        settle();

        // zero height, then the frame closed a few rows later, no idling on either side
        idle_pct = 0;
        set_all(3, 0, 5, 2);
        queue_rows(60);
        settle();
        write_reg(carf_pkg::REG_GRID_HEIGHT, int'(frame_row) + 4);
        queue_rows(4);
        settle();
        idle_pct = 31;

        sent = 0;
        while (sent < 330) begin
            if ($urandom_range(3) != 0) begin
                case ($urandom_range(9))
                    0: write_reg(carf_pkg::REG_GRID_WIDTH, 64);
                    1: write_reg(carf_pkg::REG_GRID_WIDTH, 3);
                    2: write_reg(carf_pkg::REG_GRID_WIDTH, $urandom_range(65, 127));
                    3: write_reg(carf_pkg::REG_GRID_WIDTH, $urandom_range(0, 2));
                    default: write_reg(carf_pkg::REG_GRID_WIDTH, $urandom_range(3, 64));
                endcase
            end
            if ($urandom_range(3) != 0) begin
                case ($urandom_range(7))
                    0: h = $urandom_range(1, 2);
                    1: h = $urandom_range(13, 40);
                    default: h = $urandom_range(3, 12);
                endcase
                if (h <= int'(frame_row))
                    h = int'(frame_row) + 1;
                write_reg(carf_pkg::REG_GRID_HEIGHT, h);
            end
            if ($urandom_range(3) != 0) begin
                nc = $urandom_range(1) ? $urandom_range(15) : $urandom_range(3, 6);
                write_reg(carf_pkg::REG_NEAR_CUTOFF, nc);
            end
            if ($urandom_range(3) != 0) begin
                fc = $urandom_range(1) ? int'($urandom_range(63)) : int'($urandom_range(6)) - 1;
                write_reg(carf_pkg::REG_FAR_CUTOFF, fc);
            end
            h = int'(cfg_height);
            if ($urandom_range(4) == 0)
                n = $urandom_range(1, h);
            else
                n = h * $urandom_range(1, 2);
            if (n > 40)
                n = 40;
            queue_rows(n);
            sent += n;
            settle();
        end

        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
